// File: hdl/kwp_pkg.sv
// kwp_pkg: item types, register indexes and reset values of the keypoint back-projection unit
`timescale 1ns / 1ps

package kwp_pkg;

    typedef struct packed {
        logic [15:0]        keypoint_index;
        logic [15:0]        pixel_x;
        logic [15:0]        pixel_y;
        logic signed [15:0] depth;
        logic [7:0]         red;
        logic [7:0]         green;
        logic [7:0]         blue;
    } kp_item_t;

    typedef struct packed {
        logic [15:0]        point_index;
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic signed [31:0] point_z;
        logic signed [15:0] view_x;
        logic signed [15:0] view_y;
        logic signed [15:0] view_z;
        logic [7:0]         point_red;
        logic [7:0]         point_green;
        logic [7:0]         point_blue;
    } pt_item_t;

    typedef struct packed {
        logic [15:0] index;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
    } side_t;

    localparam int CFG_INDEX_W = 3;

    localparam logic [CFG_INDEX_W-1:0] REG_FOCAL_X  = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_FOCAL_Y  = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_CENTER_X = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_CENTER_Y = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_POSE_X   = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_POSE_Y   = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_POSE_Z   = 3'd6;

    localparam logic [15:0] FOCAL_RESET    = 16'd8000;
    localparam logic [15:0] CENTER_X_RESET = 16'd5120;
    localparam logic [15:0] CENTER_Y_RESET = 16'd3840;
    localparam logic [63:0] POSE_X_RESET   = 64'h4000_0000_0000_0000;
    localparam logic [63:0] POSE_Y_RESET   = 64'h0000_4000_0000_0000;
    localparam logic [63:0] POSE_Z_RESET   = 64'h0000_0000_4000_0000;

endpackage

// File: hdl/keypoint_to_world_point_unit.sv
// keypoint_to_world_point_unit: pipelined pinhole back-projection of depth keypoints
//
// Keypoints enter on kp_valid / kp_stall with kp_data; world points leave on
// pt_valid / pt_stall with pt_data. An item moves on a channel at a clock edge
// with valid high and stall low. A keypoint with zero or negative depth is
// taken and dropped. Intrinsics and pose are written on cfg_valid / cfg_ready
// (always ready) with cfg_index and cfg_data; the user must write them only
// while the unit is empty, as the unit itself does not enforce this. One
// keypoint enters per cycle while kp_stall is low. The pipe holds the 38-stage
// restoring divider for X and Y, the 31-stage square root and the 15-stage
// divider that scales the view vector. Every stage holds a valid bit; a stage
// loads when it is empty or when the stage after it loads, so bubbles close up
// and a held output lets the stages in front keep filling. When pt_stall
// stays high, the pipe fills and then kp_stall rises. Reset empties the pipe
// and loads the default intrinsics, identity rotation and zero translation.
`timescale 1ns / 1ps

module keypoint_to_world_point_unit
    import kwp_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   kp_valid,
    output logic                   kp_stall,
    input  kp_item_t               kp_data,
    output logic                   pt_valid,
    input  logic                   pt_stall,
    output pt_item_t               pt_data,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [63:0]            cfg_data
);

    localparam int DIV_N  = 38;
    localparam int SQRT_N = 31;
    localparam int VDIV_N = 15;

    localparam int ST_P1  = 1;
    localparam int ST_P2  = 2;
    localparam int ST_D0  = 3;
    localparam int ST_P3  = ST_D0 + DIV_N;
    localparam int ST_P4  = ST_P3 + 1;
    localparam int ST_P5  = ST_P4 + 1;
    localparam int ST_P6  = ST_P5 + 1;
    localparam int ST_P7  = ST_P6 + 1;
    localparam int ST_P8  = ST_P7 + 1;
    localparam int ST_P9  = ST_P8 + 1;
    localparam int ST_P10 = ST_P9 + 1;
    localparam int ST_P11 = ST_P10 + 1;
    localparam int ST_Q0  = ST_P11 + 1;
    localparam int ST_P12 = ST_Q0 + SQRT_N;
    localparam int ST_V0  = ST_P12 + 1;
    localparam int ST_OUT = ST_V0 + VDIV_N;
    localparam int N      = ST_OUT + 1;

    // configuration registers
    logic [15:0] focal_x_reg, focal_y_reg, center_x_reg, center_y_reg;
    logic [63:0] pose_reg [3];
    logic [15:0] fx, fy;

    assign cfg_ready = 1'b1;
    assign fx = (focal_x_reg == 16'd0) ? 16'd1 : focal_x_reg;
    assign fy = (focal_y_reg == 16'd0) ? 16'd1 : focal_y_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            focal_x_reg  <= FOCAL_RESET;
            focal_y_reg  <= FOCAL_RESET;
            center_x_reg <= CENTER_X_RESET;
            center_y_reg <= CENTER_Y_RESET;
            pose_reg[0]  <= POSE_X_RESET;
            pose_reg[1]  <= POSE_Y_RESET;
            pose_reg[2]  <= POSE_Z_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_FOCAL_X:  focal_x_reg  <= cfg_data[15:0];
                REG_FOCAL_Y:  focal_y_reg  <= cfg_data[15:0];
                REG_CENTER_X: center_x_reg <= cfg_data[15:0];
                REG_CENTER_Y: center_y_reg <= cfg_data[15:0];
                REG_POSE_X:   pose_reg[0]  <= cfg_data;
                REG_POSE_Y:   pose_reg[1]  <= cfg_data;
                REG_POSE_Z:   pose_reg[2]  <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    // valid bits, stage enables and pass-through fields
    logic [N-1:0] vld_reg;
    logic [N-1:0] en;
    side_t        side_reg [N];

    assign en[N-1] = !vld_reg[N-1] || !pt_stall;
    genvar k;
    generate
        for (k = 0; k < N - 1; k++)
        begin : g_en
            assign en[k] = !vld_reg[k] || en[k+1];
        end
    endgenerate

    assign kp_stall = !en[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (en[0])
            begin
                vld_reg[0] <= kp_valid && !kp_data.depth[15] && (kp_data.depth != 16'sd0);
            end
            for (int i = 1; i < N; i++)
            begin
                if (en[i])
                begin
                    vld_reg[i] <= vld_reg[i-1];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            side_reg[0] <= {kp_data.keypoint_index, kp_data.red, kp_data.green, kp_data.blue};
        end
        for (int i = 1; i < N; i++)
        begin
            if (en[i])
            begin
                side_reg[i] <= side_reg[i-1];
            end
        end
    end

    // offsets from the principal point
    logic signed [16:0] dx_reg, dy_reg;
    logic [14:0]        z0_reg;

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            dx_reg <= $signed({1'b0, kp_data.pixel_x}) - $signed({1'b0, center_x_reg});
            dy_reg <= $signed({1'b0, kp_data.pixel_y}) - $signed({1'b0, center_y_reg});
            z0_reg <= kp_data.depth[14:0];
        end
    end

    // offset times depth
    logic signed [32:0] prx_reg, pry_reg;
    logic [14:0]        z1_reg;

    always_ff @(posedge clk)
    begin
        if (en[ST_P1])
        begin
            prx_reg <= dx_reg * $signed({1'b0, z0_reg});
            pry_reg <= dy_reg * $signed({1'b0, z0_reg});
            z1_reg  <= z0_reg;
        end
    end

    // rounded dividends
    logic [32:0] pmx, pmy;
    logic [37:0] dvx_reg, dvy_reg;
    logic        sgx_reg, sgy_reg;
    logic [14:0] z2_reg;

    assign pmx = prx_reg[32] ? 33'(-prx_reg) : 33'(prx_reg);
    assign pmy = pry_reg[32] ? 33'(-pry_reg) : 33'(pry_reg);

    always_ff @(posedge clk)
    begin
        if (en[ST_P2])
        begin
            dvx_reg <= {1'b0, pmx[30:0], 6'b0} + {23'b0, fx[15:1]};
            dvy_reg <= {1'b0, pmy[30:0], 6'b0} + {23'b0, fy[15:1]};
            sgx_reg <= prx_reg[32];
            sgy_reg <= pry_reg[32];
            z2_reg  <= z1_reg;
        end
    end

    // restoring divider, one quotient bit per stage
    logic [15:0] drx_reg [DIV_N];
    logic [15:0] dry_reg [DIV_N];
    logic [37:0] dsx_reg [DIV_N];
    logic [37:0] dsy_reg [DIV_N];
    logic        dgx_reg [DIV_N];
    logic        dgy_reg [DIV_N];
    logic [14:0] dz_reg  [DIV_N];

    genvar d;
    generate
        for (d = 0; d < DIV_N; d++)
        begin : g_div
            logic [15:0] rx_in, ry_in;
            logic [37:0] sx_in, sy_in;
            logic        gx_in, gy_in;
            logic [14:0] z_in;
            logic [16:0] tx, ty;
            logic        ge_x, ge_y;

            if (d == 0)
            begin : g_first
                assign rx_in = 16'd0;
                assign ry_in = 16'd0;
                assign sx_in = dvx_reg;
                assign sy_in = dvy_reg;
                assign gx_in = sgx_reg;
                assign gy_in = sgy_reg;
                assign z_in  = z2_reg;
            end
            else
            begin : g_next
                assign rx_in = drx_reg[d-1];
                assign ry_in = dry_reg[d-1];
                assign sx_in = dsx_reg[d-1];
                assign sy_in = dsy_reg[d-1];
                assign gx_in = dgx_reg[d-1];
                assign gy_in = dgy_reg[d-1];
                assign z_in  = dz_reg[d-1];
            end

            assign tx   = {rx_in, sx_in[37]};
            assign ty   = {ry_in, sy_in[37]};
            assign ge_x = tx >= {1'b0, fx};
            assign ge_y = ty >= {1'b0, fy};

            always_ff @(posedge clk)
            begin
                if (en[ST_D0+d])
                begin
                    drx_reg[d] <= ge_x ? 16'(tx - {1'b0, fx}) : tx[15:0];
                    dry_reg[d] <= ge_y ? 16'(ty - {1'b0, fy}) : ty[15:0];
                    dsx_reg[d] <= {sx_in[36:0], ge_x};
                    dsy_reg[d] <= {sy_in[36:0], ge_y};
                    dgx_reg[d] <= gx_in;
                    dgy_reg[d] <= gy_in;
                    dz_reg[d]  <= z_in;
                end
            end
        end
    endgenerate

    // signed camera coordinates, Q.6
    logic signed [38:0] xq_reg, yq_reg;
    logic [20:0]        z16_reg;

    always_ff @(posedge clk)
    begin
        if (en[ST_P3])
        begin
            xq_reg  <= dgx_reg[DIV_N-1] ? $signed(39'd0 - {1'b0, dsx_reg[DIV_N-1]})
                                        : $signed({1'b0, dsx_reg[DIV_N-1]});
            yq_reg  <= dgy_reg[DIV_N-1] ? $signed(39'd0 - {1'b0, dsy_reg[DIV_N-1]})
                                        : $signed({1'b0, dsy_reg[DIV_N-1]});
            z16_reg <= {dz_reg[DIV_N-1], 6'b0};
        end
    end

    // rotation products
    logic signed [38:0] opnd [3];
    logic signed [54:0] prd_reg [3][3];

    assign opnd[0] = xq_reg;
    assign opnd[1] = yq_reg;
    assign opnd[2] = $signed({18'b0, z16_reg});

    always_ff @(posedge clk)
    begin
        if (en[ST_P4])
        begin
            for (int i = 0; i < 3; i++)
            begin
                for (int j = 0; j < 3; j++)
                begin
                    prd_reg[i][j] <= $signed(pose_reg[i][63-16*j -: 16]) * opnd[j];
                end
            end
        end
    end

    // world coordinates
    logic signed [56:0] wsum [3];
    logic signed [23:0] tq   [3];
    logic signed [44:0] w_reg [3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            tq[i]   = $signed({pose_reg[i][15:0], 8'h00});
            wsum[i] = 57'(prd_reg[i][0]) + 57'(prd_reg[i][1]) + 57'(prd_reg[i][2])
                    + 57'sd8192;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[ST_P5])
        begin
            for (int i = 0; i < 3; i++)
            begin
                w_reg[i] <= 45'(wsum[i] >>> 14) + 45'(tq[i]);
            end
        end
    end

    // saturated point and offset to camera center
    logic [95:0]        pnt_reg [ST_P6:ST_OUT];
    logic signed [45:0] dv_reg  [3];
    logic [31:0]        sat     [3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            if (w_reg[i] > 45'sd2147483647)
            begin
                sat[i] = 32'h7fff_ffff;
            end
            else if (w_reg[i] < -45'sd2147483648)
            begin
                sat[i] = 32'h8000_0000;
            end
            else
            begin
                sat[i] = w_reg[i][31:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[ST_P6])
        begin
            pnt_reg[ST_P6] <= {sat[0], sat[1], sat[2]};
            for (int i = 0; i < 3; i++)
            begin
                dv_reg[i] <= 46'(tq[i]) - 46'(w_reg[i]);
            end
        end
        for (int s = ST_P6 + 1; s <= ST_OUT; s++)
        begin
            if (en[s])
            begin
                pnt_reg[s] <= pnt_reg[s-1];
            end
        end
    end

    // magnitudes and signs of the view offset
    logic [2:0]  neg_reg [ST_P7:ST_OUT-1];
    logic [44:0] m7_reg  [3];
    logic [45:0] dmag    [3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            dmag[i] = dv_reg[i][45] ? 46'(-dv_reg[i]) : 46'(dv_reg[i]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[ST_P7])
        begin
            neg_reg[ST_P7] <= {dv_reg[0][45], dv_reg[1][45], dv_reg[2][45]};
            for (int i = 0; i < 3; i++)
            begin
                m7_reg[i] <= dmag[i][44:0];
            end
        end
        for (int s = ST_P7 + 1; s <= ST_OUT - 1; s++)
        begin
            if (en[s])
            begin
                neg_reg[s] <= neg_reg[s-1];
            end
        end
    end

    // scale-down amount so the largest magnitude stays below 2^30
    logic [44:0] mor;
    logic [3:0]  shamt;
    logic [3:0]  sh8_reg;
    logic [44:0] m8_reg [3];

    assign mor = m7_reg[0] | m7_reg[1] | m7_reg[2];

    always_comb
    begin
        shamt = 4'd0;
        for (int b = 30; b < 45; b++)
        begin
            if (mor[b])
            begin
                shamt = 4'(b - 29);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[ST_P8])
        begin
            sh8_reg <= shamt;
            for (int i = 0; i < 3; i++)
            begin
                m8_reg[i] <= m7_reg[i];
            end
        end
    end

    // scaled magnitudes, carried to the view divider
    logic [29:0] mg_reg [ST_P9:ST_P12-1][3];
    logic [44:0] msh    [3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            msh[i] = m8_reg[i] >> sh8_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[ST_P9])
        begin
            for (int i = 0; i < 3; i++)
            begin
                mg_reg[ST_P9][i] <= msh[i][29:0];
            end
        end
        for (int s = ST_P9 + 1; s <= ST_P12 - 1; s++)
        begin
            if (en[s])
            begin
                mg_reg[s] <= mg_reg[s-1];
            end
        end
    end

    // squared length
    logic [59:0] sq_reg [3];
    logic [61:0] ssum_reg;

    always_ff @(posedge clk)
    begin
        if (en[ST_P10])
        begin
            for (int i = 0; i < 3; i++)
            begin
                sq_reg[i] <= mg_reg[ST_P9][i] * mg_reg[ST_P9][i];
            end
        end
        if (en[ST_P11])
        begin
            ssum_reg <= 62'(sq_reg[0]) + 62'(sq_reg[1]) + 62'(sq_reg[2]);
        end
    end

    // digit-by-digit square root, one root bit per stage
    logic [32:0] qrem_reg  [SQRT_N];
    logic [30:0] qroot_reg [SQRT_N];
    logic [61:0] qrad_reg  [SQRT_N];

    genvar q;
    generate
        for (q = 0; q < SQRT_N; q++)
        begin : g_sqrt
            logic [32:0] rem_in;
            logic [30:0] root_in;
            logic [61:0] rad_in;
            logic [34:0] r4, trial;
            logic        ge;

            if (q == 0)
            begin : g_first
                assign rem_in  = 33'd0;
                assign root_in = 31'd0;
                assign rad_in  = ssum_reg;
            end
            else
            begin : g_next
                assign rem_in  = qrem_reg[q-1];
                assign root_in = qroot_reg[q-1];
                assign rad_in  = qrad_reg[q-1];
            end

            assign r4    = {rem_in, rad_in[61:60]};
            assign trial = {2'b0, root_in, 2'b01};
            assign ge    = r4 >= trial;

            always_ff @(posedge clk)
            begin
                if (en[ST_Q0+q])
                begin
                    qrem_reg[q]  <= ge ? 33'(r4 - trial) : r4[32:0];
                    qroot_reg[q] <= {root_in[29:0], ge};
                    qrad_reg[q]  <= {rad_in[59:0], 2'b00};
                end
            end
        end
    endgenerate

    // view dividends: magnitude * 2^14 + n / 2, upper part below n
    logic [30:0] vn0_reg;
    logic [30:0] vr0_reg [3];
    logic [14:0] vs0_reg [3];
    logic [44:0] vdv     [3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            vdv[i] = {1'b0, mg_reg[ST_P12-1][i], 14'b0}
                   + {15'b0, qroot_reg[SQRT_N-1][30:1]};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[ST_P12])
        begin
            vn0_reg <= qroot_reg[SQRT_N-1];
            for (int i = 0; i < 3; i++)
            begin
                vr0_reg[i] <= {1'b0, vdv[i][44:15]};
                vs0_reg[i] <= vdv[i][14:0];
            end
        end
    end

    // view divider, one quotient bit per stage
    logic [30:0] vn_reg [VDIV_N];
    logic [30:0] vr_reg [VDIV_N][3];
    logic [14:0] vs_reg [VDIV_N][3];

    genvar v;
    generate
        for (v = 0; v < VDIV_N; v++)
        begin : g_vdiv
            logic [30:0] n_in;
            logic [30:0] r_in [3];
            logic [14:0] s_in [3];
            logic [31:0] t    [3];
            logic [2:0]  ge;

            if (v == 0)
            begin : g_first
                assign n_in = vn0_reg;
                assign r_in = vr0_reg;
                assign s_in = vs0_reg;
            end
            else
            begin : g_next
                assign n_in = vn_reg[v-1];
                assign r_in = vr_reg[v-1];
                assign s_in = vs_reg[v-1];
            end

            always_comb
            begin
                for (int i = 0; i < 3; i++)
                begin
                    t[i]  = {r_in[i], s_in[i][14]};
                    ge[i] = t[i] >= {1'b0, n_in};
                end
            end

            always_ff @(posedge clk)
            begin
                if (en[ST_V0+v])
                begin
                    vn_reg[v] <= n_in;
                    for (int i = 0; i < 3; i++)
                    begin
                        vr_reg[v][i] <= ge[i] ? 31'(t[i] - {1'b0, n_in}) : t[i][30:0];
                        vs_reg[v][i] <= {s_in[i][13:0], ge[i]};
                    end
                end
            end
        end
    endgenerate

    // output register
    logic [15:0] view_reg [3];
    logic [15:0] view_next [3];
    logic [2:0]  vneg;

    assign vneg = neg_reg[ST_OUT-1];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            if (vn_reg[VDIV_N-1] == 31'd0)
            begin
                view_next[i] = 16'd0;
            end
            else if (vneg[2-i])
            begin
                view_next[i] = 16'd0 - {1'b0, vs_reg[VDIV_N-1][i]};
            end
            else
            begin
                view_next[i] = {1'b0, vs_reg[VDIV_N-1][i]};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[ST_OUT])
        begin
            view_reg <= view_next;
        end
    end

    assign pt_valid            = vld_reg[ST_OUT];
    assign pt_data.point_index = side_reg[ST_OUT].index;
    assign pt_data.point_x     = pnt_reg[ST_OUT][95:64];
    assign pt_data.point_y     = pnt_reg[ST_OUT][63:32];
    assign pt_data.point_z     = pnt_reg[ST_OUT][31:0];
    assign pt_data.view_x      = view_reg[0];
    assign pt_data.view_y      = view_reg[1];
    assign pt_data.view_z      = view_reg[2];
    assign pt_data.point_red   = side_reg[ST_OUT].red;
    assign pt_data.point_green = side_reg[ST_OUT].green;
    assign pt_data.point_blue  = side_reg[ST_OUT].blue;

endmodule
